// ===== design/dc2cd_pkg.sv =====
// Shared constants for the day count to calendar date converter.
`timescale 1ns / 1ps

package dc2cd_pkg;

   localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;

   // Cumulative day counts at the start of each month.
   localparam logic [8:0] MONTH_START_NORM [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };
   localparam logic [8:0] MONTH_START_LEAP [12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

endpackage

// ===== design/day_count_to_calendar_date.sv =====
// Top level: pipelined conversion of a day count and millisecond count to date and time.
`timescale 1ns / 1ps
//
// Channel  Dir  Fields in tdata (lowest bit first)
// req_     in   day_count[21:0], ms_of_day[48:22], zero pad to 56
// rsp_     out  year_out[13:0], month_out[17:14], day_of_month[22:18],
//               day_of_year[31:23], hour_out[36:32], minute_out[42:37],
//               second_out[48:43], zero pad to 56
//
// Five register stages between transfer in and result valid.
// One transfer per cycle unless rsp_ stalls; the date path (year guess multiply,
// year start quotients, year start sums, year select, month search) sets the stage count.
// A stall at rsp_ freezes the whole pipe, so req_tready follows the last stage.
// Reset clears the stage valid bits only.

module day_count_to_calendar_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // day_count, ms_of_day
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // year_out, month_out, day_of_month, day_of_year,
                                    // hour_out, minute_out, second_out
);

   // Reciprocal constants, exact for the operand ranges used below.
   localparam logic [23:0] K_YEAR = 24'(((64'd400) << 32) / 64'd146097);
   localparam logic [19:0] K_100  = 20'((64'd1 << 26) / 64'd100 + 64'd1);
   localparam logic [17:0] K_400  = 18'((64'd1 << 26) / 64'd400 + 64'd1);
   localparam logic [28:0] K_1000 = 29'((64'd1 << 38) / 64'd1000 + 64'd1);
   localparam logic [20:0] K_60A  = 21'((64'd1 << 26) / 64'd60 + 64'd1);
   localparam logic [14:0] K_60B  = 15'((64'd1 << 20) / 64'd60 + 64'd1);

   logic [4:0] vld_ff;
   logic       en;

   assign en         = !vld_ff[4] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[4];

   // stage 1
   logic [21:0] d1_ff;
   logic [13:0] est1_ff, est1_in;
   logic [17:0] sec1_ff, sec1_in;
   logic [45:0] est_prod;
   logic [55:0] sec_prod;

   assign est_prod = 46'(req_tdata[21:0]) * 46'(K_YEAR);
   assign est1_in  = est_prod[45:32];
   assign sec_prod = 56'(req_tdata[48:22]) * 56'(K_1000);
   assign sec1_in  = sec_prod[55:38];

   // stage 2: quotients for candidate years est-1 .. est+2
   logic [21:0] d2_ff;
   logic        nz2_ff;
   logic [14:0] t2_ff    [4];
   logic [14:0] t2_in    [4];
   logic [12:0] q4_ff    [4];
   logic [12:0] q4_in    [4];
   logic [7:0]  q100_ff  [4];
   logic [7:0]  q100_in  [4];
   logic [5:0]  q400_ff  [4];
   logic [5:0]  q400_in  [4];
   logic [17:0] sec2_ff;
   logic [11:0] min2_ff, min2_in;
   logic [38:0] min_prod;

   always_comb begin
      logic [15:0] v100, v400;
      logic [35:0] p100;
      logic [33:0] p400;
      for (int j = 0; j < 4; j++) begin
         t2_in[j]   = 15'({1'b0, est1_ff} + 15'(j) - 15'd1);
         q4_in[j]   = 13'((16'(t2_in[j]) + 16'd3) >> 2);
         v100       = 16'(t2_in[j]) + 16'd99;
         p100       = 36'(v100) * 36'(K_100);
         q100_in[j] = p100[33:26];
         v400       = 16'(t2_in[j]) + 16'd399;
         p400       = 34'(v400) * 34'(K_400);
         q400_in[j] = p400[31:26];
      end
   end

   assign min_prod = 39'(sec1_ff) * 39'(K_60A);
   assign min2_in  = min_prod[37:26];

   // stage 3: year start sums
   logic [21:0] d3_ff;
   logic        nz3_ff;
   logic [13:0] t3_ff  [4];
   logic [23:0] ys3_ff [4];
   logic [23:0] ys3_in [4];
   logic [11:0] min3_ff;
   logic [5:0]  hr3_ff, hr3_in;
   logic [5:0]  sec3_ff, sec3_in;
   logic [26:0] hr_prod;
   logic [17:0] sec_rem;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         ys3_in[j] = 24'(24'(t2_ff[j]) * 24'd365) + 24'(q4_ff[j]) - 24'(q100_ff[j])
                   + 24'(q400_ff[j]);
      end
   end

   assign hr_prod = 27'(min2_ff) * 27'(K_60B);
   assign hr3_in  = hr_prod[25:20];
   assign sec_rem = sec2_ff - 18'(18'(min2_ff) * 18'd60);
   assign sec3_in = sec_rem[5:0];

   // stage 4: year select, day of year, leap flag
   logic [13:0] y4_ff, y4_in;
   logic [8:0]  doy4_ff, doy4_in;
   logic        lp4_ff, lp4_in;
   logic [4:0]  hr4_ff, hr4_in;
   logic [5:0]  min4_ff, min4_in;
   logic [5:0]  sec4_ff;
   logic [11:0] min_rem;

   always_comb begin
      logic [1:0]  k;
      logic [23:0] ys_lo, ys_hi, doy_w, len;
      if (nz3_ff && (ys3_ff[1] > 24'(d3_ff))) begin
         k = 2'd0;
      end else if (ys3_ff[2] <= 24'(d3_ff)) begin
         k = 2'd2;
      end else begin
         k = 2'd1;
      end
      ys_lo   = ys3_ff[k];
      ys_hi   = ys3_ff[k + 2'd1];
      doy_w   = 24'(d3_ff) - ys_lo + 24'd1;
      len     = ys_hi - ys_lo;
      y4_in   = t3_ff[k];
      doy4_in = doy_w[8:0];
      lp4_in  = (len == 24'(dc2cd_pkg::DAYS_LEAP_YEAR));
   end

   assign min_rem = min3_ff - 12'(12'(hr3_ff) * 12'd60);
   assign min4_in = min_rem[5:0];
   assign hr4_in  = (hr3_ff >= 6'd24) ? 5'(hr3_ff - 6'd24) : hr3_ff[4:0];

   // stage 5: month search
   logic [13:0] y5_ff;
   logic [3:0]  mon5_ff, mon5_in;
   logic [4:0]  mday5_ff, mday5_in;
   logic [8:0]  doy5_ff;
   logic [4:0]  hr5_ff;
   logic [5:0]  min5_ff, sec5_ff;

   always_comb begin
      logic [8:0] start;
      logic [8:0] base;
      logic [8:0] diff;
      mon5_in = 4'd1;
      base    = 9'd0;
      for (int i = 0; i < 12; i++) begin
         start = lp4_ff ? dc2cd_pkg::MONTH_START_LEAP[i] : dc2cd_pkg::MONTH_START_NORM[i];
         // a day equal to a month start total still belongs to the earlier month
         if (start < doy4_ff) begin
            mon5_in = 4'(i + 1);
            base    = start;
         end
      end
      diff     = doy4_ff - base;
      mday5_in = diff[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff    <= req_tdata[21:0];
         est1_ff  <= est1_in;
         sec1_ff  <= sec1_in;

         d2_ff    <= d1_ff;
         nz2_ff   <= (est1_ff != 14'd0);
         t2_ff    <= t2_in;
         q4_ff    <= q4_in;
         q100_ff  <= q100_in;
         q400_ff  <= q400_in;
         sec2_ff  <= sec1_ff;
         min2_ff  <= min2_in;

         d3_ff    <= d2_ff;
         nz3_ff   <= nz2_ff;
         for (int j = 0; j < 4; j++) begin
            t3_ff[j] <= t2_ff[j][13:0];
         end
         ys3_ff   <= ys3_in;
         min3_ff  <= min2_ff;
         hr3_ff   <= hr3_in;
         sec3_ff  <= sec3_in;

         y4_ff    <= y4_in;
         doy4_ff  <= doy4_in;
         lp4_ff   <= lp4_in;
         hr4_ff   <= hr4_in;
         min4_ff  <= min4_in;
         sec4_ff  <= sec3_ff;

         y5_ff    <= y4_ff;
         mon5_ff  <= mon5_in;
         mday5_ff <= mday5_in;
         doy5_ff  <= doy4_ff;
         hr5_ff   <= hr4_ff;
         min5_ff  <= min4_ff;
         sec5_ff  <= sec4_ff;
      end
   end

   assign rsp_tdata = {7'd0, sec5_ff, min5_ff, hr5_ff, doy5_ff, mday5_ff, mon5_ff, y5_ff};

endmodule

// ===== design/dc2cd_checker.sv =====
// Port-level checks for the calendar date converter, bound to the top level.
`timescale 1ns / 1ps

module dc2cd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");

   // input side stalls exactly when a result sits untaken
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not track output stall");

   a_month: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:14] != 4'd0 && rsp_tdata[17:14] <= 4'd12
                     && rsp_tdata[22:18] != 5'd0)
      else $error("month or day of month out of range");

   a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:32] < 5'd24 && rsp_tdata[42:37] < 6'd60
                     && rsp_tdata[48:43] < 6'd60)
      else $error("time of day out of range");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind day_count_to_calendar_date dc2cd_checker u_dc2cd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/day_count_to_calendar_date_tb.sv =====
// Testbench for the day count to calendar date converter: directed table plus random items.
`timescale 1ns / 1ps

module day_count_to_calendar_date_tb;

   localparam int NUM_ROWS    = 17;
   localparam int NUM_RANDOM  = 1430;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_GAP     = 18;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [8:0]  yday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } date_time_type;

   typedef struct {
      logic [21:0]   day_count;
      logic [26:0]   ms;
      bit            has_value;
      date_time_type value;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   date_time_type pending_dates[$];
   int            error_count = 0;
   int            cycle_count = 0;

   day_count_to_calendar_date dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("day_count_to_calendar_date_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // idle cycles before a transfer; at least a quarter of the items go back to back
   function automatic int unsigned draw_gap();
      int unsigned gap;
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 3) == 0) gap = 0;
      return gap;
   endfunction

   function automatic bit is_leap(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned jan1_day(input int unsigned y);
      return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
   endfunction

   function automatic date_time_type convert_timestamp(input logic [21:0] d,
                                                       input logic [26:0] ms);
      date_time_type r;
      int unsigned   dd, msw, y, doy, m, start;
      bit            lp;
      dd  = {10'd0, d};
      msw = {5'd0, ms};
      y   = 32'((longint'(dd) * 400) / 146097);
      while (y > 0 && jan1_day(y) > dd) y--;
      while (jan1_day(y + 1) <= dd) y++;
      doy = dd - jan1_day(y) + 1;
      lp  = is_leap(y);
      m   = 1;
      for (int i = 0; i < 12; i++) begin
         start = 32'(lp ? dc2cd_pkg::MONTH_START_LEAP[i] : dc2cd_pkg::MONTH_START_NORM[i]);
         if (start < doy) m = 32'(i + 1);
      end
      start    = 32'(lp ? dc2cd_pkg::MONTH_START_LEAP[m - 1]
                        : dc2cd_pkg::MONTH_START_NORM[m - 1]);
      r.year   = 14'(y);
      r.month  = 4'(m);
      r.mday   = 5'(doy - start);
      r.yday   = 9'(doy);
      r.hour   = 5'((msw / 3600000) % 24);
      r.minute = 6'((msw / 60000) % 60);
      r.second = 6'((msw / 1000) % 60);
      return r;
   endfunction

   function automatic date_time_type dt(input int y, input int mo, input int md, input int yd,
                                        input int h, input int mi, input int s);
      date_time_type r;
      r = '{14'(y), 4'(mo), 5'(md), 9'(yd), 5'(h), 6'(mi), 6'(s)};
      return r;
   endfunction

   task automatic send_timestamp(input logic [21:0] d, input logic [26:0] ms,
                                 input bit has_value, input date_time_type value);
      date_time_type model;
      int unsigned   gap;
      gap   = draw_gap();
      model = convert_timestamp(d, ms);
      if (has_value && model !== value)
         report_mismatch("table entry vs predictor", longint'(model), longint'(value));
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {7'd0, ms, d};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_dates.push_back(has_value ? value : model);
      @(negedge clock);
   endtask

   // result side: random stalls, compare each transfer
   initial begin
      date_time_type want, got;
      int unsigned   gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = '{rsp_tdata[13:0], rsp_tdata[17:14], rsp_tdata[22:18], rsp_tdata[31:23],
                 rsp_tdata[36:32], rsp_tdata[42:37], rsp_tdata[48:43]};
         if (pending_dates.size() == 0) begin
            report_mismatch("unexpected transfer", longint'(rsp_tdata), 0);
         end else begin
            want = pending_dates.pop_front();
            if (got.year !== want.year)
               report_mismatch("year", longint'(got.year), longint'(want.year));
            if (got.month !== want.month)
               report_mismatch("month", longint'(got.month), longint'(want.month));
            if (got.mday !== want.mday)
               report_mismatch("mday", longint'(got.mday), longint'(want.mday));
            if (got.yday !== want.yday)
               report_mismatch("yday", longint'(got.yday), longint'(want.yday));
            if (got.hour !== want.hour)
               report_mismatch("hour", longint'(got.hour), longint'(want.hour));
            if (got.minute !== want.minute)
               report_mismatch("minute", longint'(got.minute), longint'(want.minute));
            if (got.second !== want.second)
               report_mismatch("second", longint'(got.second), longint'(want.second));
         end
         @(negedge clock);
      end
   end

   initial begin
      table_row_type rows [NUM_ROWS];
      date_time_type none;
      logic [21:0]   d;
      logic [26:0]   ms;
      int unsigned   y, span;
      none = '0;
      rows = '{
         '{22'd0,       27'd0,        1'b1, dt(0, 1, 1, 1, 0, 0, 0)},
         '{22'd30,      27'd59999,    1'b1, dt(0, 1, 31, 31, 0, 0, 59)},
         '{22'd31,      27'd3600000,  1'b1, dt(0, 2, 1, 32, 1, 0, 0)},
         '{22'd59,      27'd86399999, 1'b1, dt(0, 2, 29, 60, 23, 59, 59)},
         '{22'd60,      27'd61000,    1'b1, dt(0, 3, 1, 61, 0, 1, 1)},
         '{22'd365,     27'd0,        1'b1, dt(0, 12, 31, 366, 0, 0, 0)},
         '{22'd366,     27'd0,        1'b1, dt(1, 1, 1, 1, 0, 0, 0)},
         '{22'd3652424, 27'd86399999, 1'b1, dt(9999, 12, 31, 365, 23, 59, 59)},
         '{22'h3FFFFF,  27'h7FFFFFF,  1'b0, none},
         '{22'd36524,   27'd0,        1'b0, none},
         '{22'd36583,   27'd0,        1'b0, none},
         '{22'd146096,  27'd0,        1'b0, none},
         '{22'd146097,  27'd0,        1'b0, none},
         '{22'd730485,  27'd86400000, 1'b0, none},
         '{22'h2AAAAA,  27'h5555555,  1'b0, none},
         '{22'h155555,  27'h2AAAAAA,  1'b0, none},
         '{22'd1000000, 27'd43200000, 1'b0, none}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_timestamp(rows[i].day_count, rows[i].ms, rows[i].has_value,
                                       rows[i].value);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM / 2) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending_dates.size() != 0) @(negedge clock);
         end
         case ($urandom_range(0, 9))
            0: begin
               d  = 22'($urandom);
               ms = 27'($urandom);
            end
            1, 2, 3: begin
               // around a year or month boundary
               y    = $urandom_range(0, 9999);
               span = jan1_day(y) + $urandom_range(0, 2) - 1;
               if ($urandom_range(0, 1) != 0)
                  span = span + 32'(dc2cd_pkg::MONTH_START_NORM[$urandom_range(0, 11)]);
               if (span > 32'd3652424) span = 32'd3652424;
               d  = 22'(span);
               ms = 27'($urandom_range(0, 86399999));
            end
            default: begin
               d  = 22'($urandom_range(0, 3652424));
               ms = 27'($urandom_range(0, 86399999));
            end
         endcase
         send_timestamp(d, ms, 1'b0, none);
      end
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0)
         $display("day_count_to_calendar_date_tb passed");
      else
         $display("day_count_to_calendar_date_tb failed");
      $finish;
   end

endmodule

// ===== day_count_to_calendar_date.f =====
design/dc2cd_pkg.sv
design/day_count_to_calendar_date.sv
design/dc2cd_checker.sv
test/day_count_to_calendar_date_tb.sv
